// ===== hdl/spq_pkg.sv =====
`default_nettype none
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int TAG_BITS = 16;
  localparam int PRIO_BITS = 8;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_POP     = 3'd1,
    OP_UPGRADE = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_PEEK    = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_GREATER  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    MODE_HOLD,
    MODE_INSERT,
    MODE_POP,
    MODE_MOVE,
    MODE_CLEAR
  } mode_t;

  // broadcast to every cell
  typedef struct packed {
    mode_t                 mode;
    logic [TAG_BITS-1:0]   tag;
    logic [PRIO_BITS-1:0]  prio;
  } ctl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                  valid;
    logic [TAG_BITS-1:0]   tag;
    logic [PRIO_BITS-1:0]  prio;
    logic                  le;
  } link_t;

  typedef struct packed {
    logic                  valid;
    logic [TAG_BITS-1:0]   tag;
    logic [PRIO_BITS-1:0]  prio;
  } slot_t;

endpackage
`default_nettype wire

// ===== hdl/stable_priority_queue_tagged_top.sv =====
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  in_opcode, in_tag, in_prio
// out      output     out_valid / out_stall out_status, out_popped_tag, out_head_tag,
//                                          out_head_prio, out_is_empty, out_occupancy
//
// one item per cycle while the output is not stalled: every operation is finished in the cell row in the cycle it
// is accepted, each cell picking its next entry from itself, its neighbors or the item
// the result sits in a one-deep output register; a new item is taken while that
// register is empty or being drained in the same cycle
// synchronous active-low reset empties the queue and the output register
`default_nettype none
module stable_priority_queue_tagged_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_opcode,
  input  logic [spq_pkg::TAG_BITS-1:0]   in_tag,
  input  logic [spq_pkg::PRIO_BITS-1:0]  in_prio,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_status,
  output logic [spq_pkg::TAG_BITS-1:0]   out_popped_tag,
  output logic [spq_pkg::TAG_BITS-1:0]   out_head_tag,
  output logic [spq_pkg::PRIO_BITS-1:0]  out_head_prio,
  output logic                           out_is_empty,
  output logic [spq_pkg::CNT_BITS-1:0]   out_occupancy
);

  localparam int D = spq_pkg::DEPTH;

  spq_pkg::ctl_t                  ctl;
  spq_pkg::link_t                 links [D];
  spq_pkg::link_t                 edge_left;
  spq_pkg::link_t                 edge_right;
  logic [D:0]                     found;
  logic [spq_pkg::PRIO_BITS-1:0]  hit_prio [D];
  spq_pkg::slot_t                 slot_nxt [D];
  logic [spq_pkg::PRIO_BITS-1:0]  match_prio;
  logic                           accept;
  spq_pkg::mode_t                 mode;
  spq_pkg::status_t               status;
  logic [spq_pkg::TAG_BITS-1:0]   popped;

  logic [spq_pkg::CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [2:0]                     status_r;
  logic [spq_pkg::TAG_BITS-1:0]   popped_r;
  logic [spq_pkg::TAG_BITS-1:0]   head_tag_r;
  logic [spq_pkg::PRIO_BITS-1:0]  head_prio_r;
  logic                           empty_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // virtual neighbors past both ends of the row
  assign edge_left.valid  = 1'b1;
  assign edge_left.tag    = '0;
  assign edge_left.prio   = '0;
  assign edge_left.le     = 1'b1;
  assign edge_right.valid = 1'b0;
  assign edge_right.tag   = '0;
  assign edge_right.prio  = '0;
  assign edge_right.le    = 1'b0;

  assign found[0] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < D; gi++) begin : g_cell
      spq_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .left_in  ((gi == 0) ? edge_left : links[(gi == 0) ? 0 : gi - 1]),
        .right_in ((gi == D - 1) ? edge_right : links[(gi == D - 1) ? gi : gi + 1]),
        .found_in (found[gi]),
        .link_out (links[gi]),
        .found_out(found[gi+1]),
        .hit_prio (hit_prio[gi]),
        .slot_nxt (slot_nxt[gi])
      );
    end
  endgenerate

  always_comb begin
    match_prio = '0;
    for (int i = 0; i < D; i++) begin
      match_prio = match_prio | hit_prio[i];
    end
  end

  always_comb begin
    mode    = spq_pkg::MODE_HOLD;
    status  = spq_pkg::ST_OK;
    popped  = '0;
    cnt_nxt = cnt_r;
    case (spq_pkg::opcode_t'(in_opcode))
      spq_pkg::OP_INSERT: begin
        if (links[D-1].valid) begin
          status = spq_pkg::ST_FULL;
        end else begin
          mode    = spq_pkg::MODE_INSERT;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      spq_pkg::OP_POP: begin
        if (!links[0].valid) begin
          status = spq_pkg::ST_EMPTY;
        end else begin
          mode    = spq_pkg::MODE_POP;
          popped  = links[0].tag;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      spq_pkg::OP_UPGRADE: begin
        if (!links[0].valid) begin
          status = spq_pkg::ST_EMPTY;
        end else if (!found[D]) begin
          status = spq_pkg::ST_NOTFOUND;
        end else if (in_prio > match_prio) begin
          status = spq_pkg::ST_GREATER;
        end else begin
          mode = spq_pkg::MODE_MOVE;
        end
      end
      spq_pkg::OP_CLEAR: begin
        mode    = spq_pkg::MODE_CLEAR;
        cnt_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign ctl.mode = accept ? mode : spq_pkg::MODE_HOLD;
  assign ctl.tag  = in_tag;
  assign ctl.prio = in_prio;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status;
      popped_r    <= popped;
      head_tag_r  <= slot_nxt[0].valid ? slot_nxt[0].tag : '0;
      head_prio_r <= slot_nxt[0].valid ? slot_nxt[0].prio : '0;
      empty_r     <= !slot_nxt[0].valid;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_popped_tag = popped_r;
  assign out_head_tag   = head_tag_r;
  assign out_head_prio  = head_prio_r;
  assign out_is_empty   = empty_r;
  assign out_occupancy  = cnt_r;

endmodule
`default_nettype wire

// ===== hdl/spq_cell.sv =====
`default_nettype none
module spq_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  spq_pkg::ctl_t                  ctl,
  input  spq_pkg::link_t                 left_in,
  input  spq_pkg::link_t                 right_in,
  input  logic                           found_in,
  output spq_pkg::link_t                 link_out,
  output logic                           found_out,
  output logic [spq_pkg::PRIO_BITS-1:0]  hit_prio,
  output spq_pkg::slot_t                 slot_nxt
);

  logic                           valid_r, valid_nxt;
  logic [spq_pkg::TAG_BITS-1:0]   tag_r, tag_nxt;
  logic [spq_pkg::PRIO_BITS-1:0]  prio_r, prio_nxt;
  logic                           hit;
  spq_pkg::link_t                 self_link;
  spq_pkg::link_t                 s_sel;
  spq_pkg::link_t                 l_sel;

  assign hit       = valid_r && (tag_r == ctl.tag);
  assign found_out = found_in | hit;
  assign hit_prio  = (hit && !found_in) ? prio_r : '0;

  assign self_link.valid = valid_r;
  assign self_link.tag   = tag_r;
  assign self_link.prio  = prio_r;
  assign self_link.le    = valid_r && (prio_r <= ctl.prio);
  assign link_out        = self_link;

  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    prio_nxt  = prio_r;
    s_sel     = self_link;
    l_sel     = left_in;
    case (ctl.mode)
      spq_pkg::MODE_INSERT, spq_pkg::MODE_MOVE: begin
        if (ctl.mode == spq_pkg::MODE_INSERT) begin
          valid_nxt = valid_r | left_in.valid;
        end else begin
          // cells from the removed entry onward look one place to the right
          s_sel = found_out ? right_in : self_link;
          l_sel = found_in ? self_link : left_in;
        end
        if (s_sel.le) begin
          tag_nxt  = s_sel.tag;
          prio_nxt = s_sel.prio;
        end else if (l_sel.le) begin
          tag_nxt  = ctl.tag;
          prio_nxt = ctl.prio;
        end else begin
          tag_nxt  = l_sel.tag;
          prio_nxt = l_sel.prio;
        end
      end
      spq_pkg::MODE_POP: begin
        valid_nxt = right_in.valid;
        tag_nxt   = right_in.tag;
        prio_nxt  = right_in.prio;
      end
      spq_pkg::MODE_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign slot_nxt.valid = valid_nxt;
  assign slot_nxt.tag   = tag_nxt;
  assign slot_nxt.prio  = prio_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    prio_r <= prio_nxt;
  end

endmodule
`default_nettype wire
